@@ rtl/cos_sim_pkg.sv @@
// Shared constants, widths, status codes and control structs for the
// cosine similarity block. Depends on nothing; every other file uses it.
package cos_sim_pkg;

  localparam int MAX_LEN  = 4096;
  localparam int DATA_W   = 16;
  localparam int STATUS_W = 2;

  // Element counter holds 0..MAX_LEN.
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  // A square term is at most 2^30, so MAX_LEN of them fit in NORM_W bits.
  localparam int NORM_W = $clog2(MAX_LEN) + 31;
  localparam int DOT_W  = NORM_W + 1;
  localparam int ROOT_W = NORM_W;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int QUO_W  = DATA_W;

  // Step counter counts down from the longest phase length minus one.
  localparam int STEP_W = $clog2(NORM_W);
  localparam logic [STEP_W-1:0] MUL_LAST_STEP  = STEP_W'(NORM_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST_STEP = STEP_W'(ROOT_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST_STEP  = STEP_W'(QUO_W - 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_NORM = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic acc_en;     // an element pair transfers this cycle
    logic load;       // prime multiplier, root and divider
    logic mul_step;   // one shift-add step of norm_a * norm_b
    logic sqrt_step;  // one digit of the integer square root
    logic div_step;   // one quotient bit
    logic div_first;  // first quotient bit (integer part, no shift)
    logic out_load;   // capture the result and clear the accumulators
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;        // too long or a zero norm: skip the arithmetic
  } dp_stat_t;

endpackage

@@ rtl/cos_sim_if.sv @@
// Valid/ready stream interfaces for the element pair input and the score
// output. Depends on cos_sim_pkg for field widths.
interface cos_sim_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [cos_sim_pkg::DATA_W-1:0]  elem_a;
  logic signed [cos_sim_pkg::DATA_W-1:0]  elem_b;
  logic                                   last;

  modport source (output valid, output elem_a, output elem_b, output last, input ready);
  modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

interface cos_sim_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [cos_sim_pkg::DATA_W-1:0]  score;
  logic [cos_sim_pkg::STATUS_W-1:0]       status;

  modport source (output valid, output score, output status, input ready);
  modport sink   (input valid, input score, input status, output ready);
endinterface

@@ rtl/cos_sim_dp.sv @@
// Datapath: three accumulators, a shift-add multiplier, a digit-by-digit
// square root, a restoring divider and the result register. Uses cos_sim_pkg.
module cos_sim_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cos_sim_pkg::dp_cmd_t                  cmd_i,
  input  logic signed [cos_sim_pkg::DATA_W-1:0] elem_a_i,
  input  logic signed [cos_sim_pkg::DATA_W-1:0] elem_b_i,
  output cos_sim_pkg::dp_stat_t                 stat_o,
  output logic signed [cos_sim_pkg::DATA_W-1:0] score_o,
  output logic [cos_sim_pkg::STATUS_W-1:0]      status_o
);
  import cos_sim_pkg::*;

  logic signed [DOT_W-1:0]  dot_q;
  logic [NORM_W-1:0]        norm_a_q, norm_b_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     too_long_q;

  logic signed [2*DATA_W-1:0] prod_ab, prod_aa, prod_bb;
  logic                       full;
  logic                       zero_norm;

  logic [RAD_W-1:0]   mcand_q;
  logic [NORM_W-1:0]  mplier_q;
  logic [RAD_W-1:0]   rad_q;
  logic [REM_W-1:0]   rem_q;
  logic [ROOT_W-1:0]  root_q;
  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   trial;

  logic [DOT_W-1:0]   mag;
  logic [ROOT_W:0]    drem_q;
  logic [ROOT_W:0]    dtry;
  logic [QUO_W-1:0]   quo_q;
  logic               dot_neg;
  logic [DATA_W-1:0]  sat_score;

  logic signed [DATA_W-1:0] score_q;
  status_e                  status_q;

  assign prod_ab   = elem_a_i * elem_b_i;
  assign prod_aa   = elem_a_i * elem_a_i;
  assign prod_bb   = elem_b_i * elem_b_i;
  assign full      = (cnt_q == CNT_W'(MAX_LEN));
  assign zero_norm = (norm_a_q == '0) || (norm_b_q == '0);
  assign stat_o.err = too_long_q || zero_norm;

  // Running sums; cleared once the result has been captured.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q      <= '0;
      norm_a_q   <= '0;
      norm_b_q   <= '0;
      cnt_q      <= '0;
      too_long_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      dot_q      <= '0;
      norm_a_q   <= '0;
      norm_b_q   <= '0;
      cnt_q      <= '0;
      too_long_q <= 1'b0;
    end else if (cmd_i.acc_en) begin
      if (full) begin
        too_long_q <= 1'b1;
      end else begin
        dot_q    <= dot_q + DOT_W'(prod_ab);
        norm_a_q <= norm_a_q + NORM_W'(prod_aa[2*DATA_W-2:0]);
        norm_b_q <= norm_b_q + NORM_W'(prod_bb[2*DATA_W-2:0]);
        cnt_q    <= cnt_q + 1'b1;
      end
    end
  end

  // Square root: bring down the next two radicand bits, try (root << 2) | 1.
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  // The multiplier builds norm_a * norm_b in rad_q; the root then shifts it out.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mcand_q  <= RAD_W'(norm_a_q);
      mplier_q <= norm_b_q;
      rad_q    <= '0;
      rem_q    <= '0;
      root_q   <= '0;
    end else if (cmd_i.mul_step) begin
      if (mplier_q[0]) begin
        rad_q <= rad_q + mcand_q;
      end
      mcand_q  <= {mcand_q[RAD_W-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[NORM_W-1:1]};
    end else if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Divider: |dot| never exceeds the root, so the quotient is at most 2^15.
  assign dot_neg = dot_q[DOT_W-1];
  assign mag     = dot_neg ? DOT_W'(-dot_q) : DOT_W'(dot_q);
  assign dtry    = cmd_i.div_first ? drem_q : {drem_q[ROOT_W-1:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      drem_q <= mag;
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (dtry >= {1'b0, root_q}) begin
        drem_q <= dtry - {1'b0, root_q};
        quo_q  <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        drem_q <= dtry;
        quo_q  <= {quo_q[QUO_W-2:0], 1'b0};
      end
    end
  end

  // Negation of 32768 wraps to -32768; a positive 32768 saturates.
  always_comb begin
    if (dot_neg) begin
      sat_score = DATA_W'(~quo_q + 1'b1);
    end else if (quo_q[QUO_W-1]) begin
      sat_score = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat_score = quo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      priority if (too_long_q) begin
        score_q  <= '0;
        status_q <= ST_TOO_LONG;
      end else if (zero_norm) begin
        score_q  <= '0;
        status_q <= ST_ZERO_NORM;
      end else begin
        score_q  <= sat_score;
        status_q <= ST_OK;
      end
    end
  end

  assign score_o  = score_q;
  assign status_o = status_q;

endmodule

@@ rtl/cos_sim_ctrl.sv @@
// Controller: sequences accumulation, multiply, root, divide and result
// hand-off, and owns the output valid flag. Uses cos_sim_pkg.
module cos_sim_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_last_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output cos_sim_pkg::dp_cmd_t   cmd_o,
  input  cos_sim_pkg::dp_stat_t  stat_i
);
  import cos_sim_pkg::*;

  typedef enum logic [5:0] {
    S_ACC   = 6'b000001,
    S_CHECK = 6'b000010,
    S_MUL   = 6'b000100,
    S_SQRT  = 6'b001000,
    S_DIV   = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               out_valid_q, out_valid_d;
  logic               in_xfer;
  logic               slot_free;

  assign in_ready_o  = (state_q == S_ACC);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.acc_en = in_xfer;
    unique case (state_q)
      S_ACC: begin
        if (in_xfer && in_last_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.err) begin
          state_d = S_FIN;
        end else begin
          cmd_o.load = 1'b1;
          step_d     = MUL_LAST_STEP;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (step_q == '0) begin
          step_d  = SQRT_LAST_STEP;
          state_d = S_SQRT;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (step_q == '0) begin
          step_d  = DIV_LAST_STEP;
          state_d = S_DIV;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (step_q == DIV_LAST_STEP);
        if (step_q == '0) begin
          state_d = S_FIN;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/cosine_similarity_top.sv @@
// Top level of the streaming cosine similarity block: joins the controller
// and the datapath to the two stream interfaces. Uses cos_sim_pkg.
//
// Usage: element pairs (elem_a, elem_b, signed Q1.15) arrive on in_i, one
// transfer per cycle while the block is accumulating. The pair with last set
// closes the vectors. One result (score in Q1.15, status) then leaves on
// out_o. Pairs without last produce no result.
// Compute: after the final pair the input is held off while the result is
// computed: a check state, shift-add steps for norm_a * norm_b, the
// two-bits-per-step square root, the restoring divider and a final state
// that captures the result once the output register is free. If a vector
// is too long or has a zero norm, the arithmetic is skipped and the check
// state goes straight to the final state.
// Output: the result sits in an output register; the block clears its
// accumulators and accepts the next vector while that result waits. A
// stalled receiver delays the capture of the following result.
// Reset: rst_ni clears the accumulators, the controller and the output valid.
module cosine_similarity_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  cos_sim_in_if.sink   in_i,
  cos_sim_out_if.source out_o
);
  import cos_sim_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cos_sim_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  cos_sim_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .elem_a_i (in_i.elem_a),
    .elem_b_i (in_i.elem_b),
    .stat_o   (stat),
    .score_o  (out_o.score),
    .status_o (out_o.status)
  );

  // Once the final pair transfers, the input stays closed for the compute.
  a_last_closes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.last) |=> !in_i.ready)
    else $error("input still open after the final pair");

  // Any error status comes with a zero score.
  a_err_zero_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != ST_OK)) |-> (out_o.score == '0))
    else $error("nonzero score with an error status");

  // A new result is only captured while the input is closed.
  a_result_after_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> !$past(in_i.ready))
    else $error("result appeared while accumulating");

  // Status code three is never produced.
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.status != 2'd3))
    else $error("illegal status code");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for cosine_similarity_top: streams element pairs,
// predicts each score and status, and checks every result in order.
// Depends on cos_sim_pkg, cos_sim_in_if / cos_sim_out_if and the RTL top.
module tb;
  import cos_sim_pkg::*;

  // Run shape. The reset, the hold-off and the drain are the only fixed waits.
  localparam int RANDOM_PAIRS   = 500;
  localparam int HOLD_AT_RESULT = 12;
  localparam int HOLD_CYCLES    = 800;
  localparam int DRAIN_CYCLES   = 150;
  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer
  localparam longint SCORE_MAX  = 2 ** (DATA_W - 1) - 1;
  localparam longint SCORE_MIN  = 2 ** (DATA_W - 1);  // magnitude of the minimum

  typedef struct {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic                     last;
  } pair_t;

  typedef struct {
    logic signed [DATA_W-1:0] score;
    status_e                  status;
  } result_t;

  // Shapes of generated vectors.
  typedef enum int {
    VEC_RANDOM,
    VEC_ALIGNED,
    VEC_OPPOSED,
    VEC_SPARSE,
    VEC_ZERO_A,
    VEC_ZERO_B
  } vec_shape_e;

  // Receiver stall patterns.
  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  cos_sim_in_if  in_if ();
  cos_sim_out_if out_if ();

  cosine_similarity_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Pairs waiting to be offered, and scores waiting to come out.
  pair_t   pending_pairs[$];
  result_t expected_scores[$];

  // Predictor state: the running sums the block should be holding.
  logic signed [DOT_W-1:0] acc_dot    = '0;
  logic [NORM_W-1:0]       acc_norm_a = '0;
  logic [NORM_W-1:0]       acc_norm_b = '0;
  logic [CNT_W-1:0]        pair_count = '0;
  bit                      overlong   = 1'b0;

  int    total_pairs    = 0;
  int    pairs_accepted = 0;
  int    results_seen   = 0;
  int    zero_norm_seen = 0;
  int    overlong_seen  = 0;
  int    fail_count     = 0;
  int    burst_left     = 0;
  int    gap_left       = 0;
  int    rx_cycle       = 0;
  int    rx_hold_left   = 0;
  bit    rx_hold_done   = 1'b0;
  int    idle_cycles    = 0;
  pair_t next_pair;
  result_t want;
  rx_mode_e rx_mode = RX_ALWAYS;

  // Folds one accepted pair into the running sums. On the closing pair it
  // works out the score the block must produce and clears the sums.
  function automatic void fold_pair(input logic signed [DATA_W-1:0] a,
                                    input logic signed [DATA_W-1:0] b,
                                    input logic last);
    longint     sa;
    longint     sb;
    longint     mag;
    bit [127:0] radicand;
    bit [127:0] root;
    bit [127:0] trial;
    bit [127:0] quo;
    bit         neg;
    result_t    res;
    sa = a;
    sb = b;
    // Once the counter is full, further pairs are dropped and only flagged.
    if (pair_count >= CNT_W'(MAX_LEN)) begin
      overlong = 1'b1;
    end else begin
      acc_dot    = acc_dot + DOT_W'(sa * sb);
      acc_norm_a = acc_norm_a + NORM_W'(sa * sa);
      acc_norm_b = acc_norm_b + NORM_W'(sb * sb);
      pair_count = pair_count + 1'b1;
    end
    if (!last) return;

    res.score = '0;
    if (overlong) begin
      res.status = ST_TOO_LONG;
    end else if (acc_norm_a == 0 || acc_norm_b == 0) begin
      res.status = ST_ZERO_NORM;
    end else begin
      res.status = ST_OK;
      // Integer square root of the norm product, rounded down.
      radicand = 128'(acc_norm_a) * 128'(acc_norm_b);
      root = '0;
      for (int i = 62; i >= 0; i--) begin
        trial = root | (128'd1 << i);
        if (trial * trial <= radicand) root = trial;
      end
      // Divide the magnitude and put the sign back, saturating at full scale.
      neg = acc_dot < 0;
      mag = neg ? -longint'(acc_dot) : longint'(acc_dot);
      quo = (128'(mag) << 15) / root;
      if (neg) begin
        res.score = (quo > 128'(SCORE_MIN)) ? DATA_W'(-SCORE_MIN) : DATA_W'(-quo);
      end else begin
        res.score = (quo > 128'(SCORE_MAX)) ? DATA_W'(SCORE_MAX) : DATA_W'(quo);
      end
    end
    expected_scores = {expected_scores, res};

    acc_dot    = '0;
    acc_norm_a = '0;
    acc_norm_b = '0;
    pair_count = '0;
    overlong   = 1'b0;
  endfunction

  task automatic push_pair(input logic signed [DATA_W-1:0] a,
                           input logic signed [DATA_W-1:0] b,
                           input logic last);
    pair_t p;
    p.a = a;
    p.b = b;
    p.last = last;
    pending_pairs = {pending_pairs, p};
  endtask

  // Element values lean toward the extremes, zero and tiny magnitudes; the
  // rest are full 16-bit random words so that every bit toggles.
  function automatic logic signed [DATA_W-1:0] pick_elem();
    logic signed [DATA_W-1:0] e;
    case ($urandom_range(0, 7))
      0: e = DATA_W'(-SCORE_MIN);
      1: e = DATA_W'(SCORE_MAX);
      2: e = '0;
      3: begin
        e = DATA_W'($urandom_range(0, 16));
        e = e - 16'sd8;
      end
      default: e = DATA_W'($urandom);
    endcase
    return e;
  endfunction

  task automatic queue_vector(input int len, input vec_shape_e shape);
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      a = pick_elem();
      b = pick_elem();
      case (shape)
        VEC_ALIGNED: begin
          // Nearly parallel vectors push the score toward plus full scale.
          b = a;
          if ($urandom_range(0, 3) == 0) b = b + DATA_W'($urandom_range(0, 3));
        end
        VEC_OPPOSED: b = -a;
        VEC_SPARSE: begin
          if ($urandom_range(0, 3) != 0) a = '0;
          if ($urandom_range(0, 3) != 0) b = '0;
        end
        VEC_ZERO_A: a = '0;
        VEC_ZERO_B: b = '0;
        default: ;
      endcase
      push_pair(a, b, i == len - 1);
    end
  endtask

  // Clock and the single reset pulse. All block inputs are known from time 0.
  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.elem_a = '0;
    in_if.elem_b = '0;
    in_if.last   = 1'b0;
    out_if.ready = 1'b0;
    fork
      forever #10 clk_i = ~clk_i;
      begin
        repeat (6) @(posedge clk_i);
        @(negedge clk_i) rst_ni = 1'b1;
      end
    join_none
  end

  // Stimulus, then the end of the run.
  initial begin
    int len;
    int pick;
    int random_pairs;
    vec_shape_e shape;

    // Single-pair vectors at the corners of the range. Minus one times minus
    // one and full scale times full scale both have to saturate upward,
    // while minus one against plus full scale lands exactly on the minimum.
    push_pair(-16'sd32768, -16'sd32768, 1'b1);
    push_pair(-16'sd32768, 16'sd32767, 1'b1);
    push_pair(16'sd32767, 16'sd32767, 1'b1);
    // Zero norm in the first, the second and both vectors.
    push_pair(16'sd0, 16'sd5, 1'b1);
    push_pair(16'sd5, 16'sd0, 1'b1);
    push_pair(16'sd0, 16'sd0, 1'b1);
    // Leading zero pairs followed by a tiny negative product.
    push_pair(16'sd0, 16'sd0, 1'b0);
    push_pair(16'sd0, 16'sd0, 1'b0);
    push_pair(16'sd1, -16'sd1, 1'b1);
    // Ordinary short vectors with truncated root and quotient.
    push_pair(16'sd1, 16'sd2, 1'b0);
    push_pair(16'sd3, -16'sd4, 1'b1);
    push_pair(16'sd32767, -16'sd32768, 1'b0);
    push_pair(-16'sd32768, 16'sd32767, 1'b1);
    // First vector all zero over several pairs.
    push_pair(16'sd0, 16'sd7, 1'b0);
    push_pair(16'sd0, -16'sd3, 1'b0);
    push_pair(16'sd0, 16'sd1, 1'b1);
    // The next vector must start from cleared sums.
    push_pair(16'sd3, 16'sd4, 1'b1);

    // Random vectors, mostly short so that results come often.
    random_pairs = 0;
    while (random_pairs < RANDOM_PAIRS) begin
      pick = $urandom_range(0, 19);
      if (pick < 16) len = $urandom_range(1, 8);
      else if (pick < 19) len = $urandom_range(9, 40);
      else len = $urandom_range(100, 200);
      pick = $urandom_range(0, 24);
      if (pick < 10) shape = VEC_RANDOM;
      else if (pick < 15) shape = VEC_ALIGNED;
      else if (pick < 20) shape = VEC_OPPOSED;
      else if (pick < 23) shape = VEC_SPARSE;
      else if (pick < 24) shape = VEC_ZERO_A;
      else shape = VEC_ZERO_B;
      queue_vector(len, shape);
      random_pairs += len;
    end
    total_pairs = pending_pairs.size();

    // Wait for every pair to transfer and every score to arrive, then give
    // the block time to show any result nobody asked for.
    wait (rst_ni);
    while (pairs_accepted < total_pairs || expected_scores.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d element pairs closing %0d vectors (%0d zero-norm, %0d over-length),",
             pairs_accepted, results_seen, zero_norm_seen, overlong_seen);
    $display("with bursty input, mixed output stalls and one %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Input driver. A pair that transfers at this edge goes into the predictor;
  // the next one is offered in bursts of random length with random gaps, and
  // an offered pair is held until it transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      in_if.elem_a <= '0;
      in_if.elem_b <= '0;
      in_if.last   <= 1'b0;
      burst_left   = 0;
      gap_left     = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        fold_pair(in_if.elem_a, in_if.elem_b, in_if.last);
        pairs_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0 || pending_pairs.size() == 0) begin
          in_if.valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          next_pair = pending_pairs.pop_front();
          in_if.valid  <= 1'b1;
          in_if.elem_a <= next_pair.a;
          in_if.elem_b <= next_pair.b;
          in_if.last   <= next_pair.last;
          if (burst_left <= 1) begin
            // Occasionally a long burst with no gaps at all.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Output monitor. Every result is checked against the oldest prediction.
  // Ready follows a randomly redrawn stall pattern, and once, after a
  // fixed number of results, it stays low long enough that the output
  // register and the finished next result back up into the input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_scores.size() == 0) begin
          $error("unexpected result: score %0d status %0d", out_if.score, out_if.status);
          fail_count++;
        end else begin
          want = expected_scores.pop_front();
          if (out_if.score !== want.score) begin
            $error("score: expected %0d, got %0d", want.score, out_if.score);
            fail_count++;
          end
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            fail_count++;
          end
        end
        results_seen++;
        if (out_if.status == ST_ZERO_NORM) zero_norm_seen++;
        if (out_if.status == ST_TOO_LONG) overlong_seen++;
      end

      rx_cycle++;
      if (rx_cycle % 256 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_if.ready <= 1'b0;
      end else if (!rx_hold_done && results_seen == HOLD_AT_RESULT) begin
        rx_hold_done = 1'b1;
        rx_hold_left = HOLD_CYCLES - 1;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:   out_if.ready <= 1'b1;
          RX_RANDOM:   out_if.ready <= ($urandom_range(0, 3) != 0);
          RX_PERIODIC: out_if.ready <= ((rx_cycle % 7) >= 3);
          default:     out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: a run in which nothing transfers for too long has hung.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $error("no transfer for %0d cycles, %0d of %0d pairs sent, %0d results pending",
               idle_cycles, pairs_accepted, total_pairs, expected_scores.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
